### src/hrt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hrt_pkg;

   localparam int unsigned RATIO_W = 32;
   localparam int unsigned SUM_W   = 2 * RATIO_W;
   localparam int unsigned CNT_W   = $clog2(RATIO_W);

   localparam logic [5:0]         MAX_ORDER       = 6'd50;
   localparam logic [5:0]         FIRST_HARMONIC  = 6'd2;
   localparam logic [RATIO_W-1:0] ZERO_FUND_SUBST = 32'd50000;
   localparam logic [6:0]         PERCENT_SCALE   = 7'd100;

   // status of one serial arithmetic unit
   typedef struct packed {
      logic busy;
      logic done;   // one-cycle pulse, result valid from this cycle on
   } unit_sts_type;

endpackage

`default_nettype wire

### src/hrt_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Bit-serial restoring divider: (amp * 100 << 16) / fund, saturated to 32 bits.
module hrt_div import hrt_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [RATIO_W-1:0] amp,
   input  wire logic [RATIO_W-1:0] fund,
   output logic      [RATIO_W-1:0] quot,
   output unit_sts_type            sts
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [RATIO_W-1:0] rem_ff, rem_in;
   logic [RATIO_W-1:0] sh_ff, sh_in;
   logic [RATIO_W-1:0] dvs_ff, dvs_in;

   logic [RATIO_W-1:0] fund_eff;
   logic [38:0]        scaled;
   logic               sat;
   logic [RATIO_W:0]   trial;
   logic [RATIO_W:0]   diff;
   logic               fits;

   always_comb begin
      fund_eff = (fund == '0) ? ZERO_FUND_SUBST : fund;
      scaled   = 39'(amp) * 39'(PERCENT_SCALE);
      // quotient >= 2^32 exactly when the top part alone reaches the divisor
      sat      = {9'b0, scaled[38:16]} >= fund_eff;
      trial    = {rem_ff, sh_ff[RATIO_W-1]};
      diff     = trial - {1'b0, dvs_ff};
      fits     = trial >= {1'b0, dvs_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      dvs_in  = dvs_ff;

      if (start) begin
         dvs_in = fund_eff;
         cnt_in = CNT_W'(RATIO_W - 1);
         if (sat) begin
            sh_in   = '1;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            rem_in  = {9'b0, scaled[38:16]};
            sh_in   = {scaled[15:0], 16'b0};
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = fits ? diff[RATIO_W-1:0] : trial[RATIO_W-1:0];
         sh_in  = {sh_ff[RATIO_W-2:0], fits};   // quotient bits fill from the right
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      dvs_ff <= dvs_in;
   end

   assign quot     = sh_ff;
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule

`default_nettype wire

### src/hrt_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// Shift-add squarer, one multiplier bit per cycle.
module hrt_mul import hrt_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [RATIO_W-1:0] a,
   output logic      [SUM_W-1:0]   product,
   output unit_sts_type            sts
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [RATIO_W-1:0] a_ff, a_in;
   logic [RATIO_W-1:0] hi_ff, hi_in;
   logic [RATIO_W-1:0] lo_ff, lo_in;
   logic [RATIO_W:0]   sum;

   always_comb begin
      sum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : '0);

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;

      if (start) begin
         a_in    = a;
         hi_in   = '0;
         lo_in   = a;
         cnt_in  = CNT_W'(RATIO_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         hi_in  = sum[RATIO_W:1];
         lo_in  = {sum[0], lo_ff[RATIO_W-1:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
   end

   assign product  = {hi_ff, lo_ff};
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule

`default_nettype wire

### src/hrt_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// Digit-by-digit integer square root, two radicand bits per cycle.
module hrt_sqrt import hrt_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [SUM_W-1:0]   v,
   output logic      [RATIO_W-1:0] root,
   output unit_sts_type            sts
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SUM_W-1:0]   val_ff, val_in;
   logic [RATIO_W:0]   rem_ff, rem_in;
   logic [RATIO_W-1:0] root_ff, root_in;

   logic [RATIO_W+2:0] r;
   logic [RATIO_W+2:0] trial;
   logic [RATIO_W+2:0] diff;
   logic               ge;

   always_comb begin
      r     = {rem_ff, val_ff[SUM_W-1:SUM_W-2]};
      trial = {1'b0, root_ff, 2'b01};
      diff  = r - trial;
      ge    = r >= trial;

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;

      if (start) begin
         val_in  = v;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(RATIO_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         val_in  = {val_ff[SUM_W-3:0], 2'b00};
         // remainder stays at most twice the partial root
         rem_in  = ge ? diff[RATIO_W:0] : r[RATIO_W:0];
         root_in = {root_ff[RATIO_W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root     = root_ff;
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule

`default_nettype wire

### src/harmonic_ratio_thd_top.sv
// Harmonic ratio and THD for one channel.
// Input channel (req_*): one word per harmonic order, carrying the order, the
// channel's fundamental amplitude, this order's amplitude and channel_end.
// Result channel (rsp_*): exactly one word per input word, in order. It holds
// the ratio amp*100/fund in Q16.16 percent (zero fundamental read as 50000)
// and, on the channel_end word, total/odd/even THD with thd_valid set; the
// odd and even square sums are cleared after that word.
// One word is processed at a time; req_ready is high only while idle.
// The serial divider (cut short when the ratio saturates) and the serial
// squarer set the pace; a channel_end word also passes through the three
// parallel square-root units. Only then is the result written to the
// output register and the block returns to idle to take the next word.
// A finished word sits in the output register; a stalled receiver holds the
// block in its final state until rsp_ready, then it returns to idle and
// takes the next word. Reset (synchronous) clears the sums, drops rsp_valid
// and returns to idle; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module harmonic_ratio_thd_top import hrt_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [5:0]         req_harmonic_order,
   input  wire logic [RATIO_W-1:0] req_fundamental_amp,
   input  wire logic [RATIO_W-1:0] req_harmonic_amp,
   input  wire logic               req_channel_end,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic      [RATIO_W-1:0] rsp_harmonic_ratio,
   output logic      [RATIO_W-1:0] rsp_total_thd,
   output logic      [RATIO_W-1:0] rsp_odd_thd,
   output logic      [RATIO_W-1:0] rsp_even_thd,
   output logic                    rsp_thd_valid
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DIV    = 6'b000010,
      S_MUL    = 6'b000100,
      S_ACC    = 6'b001000,
      S_ROOT   = 6'b010000,
      S_FIN    = 6'b100000
   } state_type;

   state_type          state_ff, state_in;

   // latched word fields
   logic [5:0]         order_ff, order_in;
   logic               last_ff, last_in;
   logic [RATIO_W-1:0] ratio_ff, ratio_in;

   // running sums
   logic [SUM_W-1:0]   odd_sum_ff, odd_sum_in;
   logic [SUM_W-1:0]   even_sum_ff, even_sum_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RATIO_W-1:0] rsp_ratio_ff, rsp_ratio_in;
   logic [RATIO_W-1:0] rsp_total_ff, rsp_total_in;
   logic [RATIO_W-1:0] rsp_odd_ff, rsp_odd_in;
   logic [RATIO_W-1:0] rsp_even_ff, rsp_even_in;
   logic               rsp_thdv_ff, rsp_thdv_in;

   logic               req_fire;
   logic               div_start, mul_start, root_start;
   logic [RATIO_W-1:0] div_quot;
   logic [SUM_W-1:0]   square;
   unit_sts_type       div_sts, mul_sts;
   unit_sts_type       sq_sts [3];
   logic [RATIO_W-1:0] root_total, root_odd, root_even;

   logic               in_range;
   logic [SUM_W:0]     acc_sum;
   logic [SUM_W:0]     tot_sum;
   logic [SUM_W-1:0]   tot_sat;
   logic               out_free;

   hrt_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .amp   (req_harmonic_amp),
      .fund  (req_fundamental_amp),
      .quot  (div_quot),
      .sts   (div_sts)
   );

   hrt_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (div_quot),
      .product (square),
      .sts     (mul_sts)
   );

   hrt_sqrt u_sqrt_total (
      .clock (clock),
      .reset (reset),
      .start (root_start),
      .v     (tot_sat),
      .root  (root_total),
      .sts   (sq_sts[0])
   );

   hrt_sqrt u_sqrt_odd (
      .clock (clock),
      .reset (reset),
      .start (root_start),
      .v     (odd_sum_ff),
      .root  (root_odd),
      .sts   (sq_sts[1])
   );

   hrt_sqrt u_sqrt_even (
      .clock (clock),
      .reset (reset),
      .start (root_start),
      .v     (even_sum_ff),
      .root  (root_even),
      .sts   (sq_sts[2])
   );

   always_comb begin
      req_ready = (state_ff == S_IDLE);
      req_fire  = req_valid && req_ready;
      out_free  = !rsp_valid_ff || rsp_ready;

      in_range = (order_ff >= FIRST_HARMONIC) && (order_ff <= MAX_ORDER);
      // odd orders go to the odd sum, even orders to the even sum
      acc_sum  = {1'b0, (order_ff[0] ? odd_sum_ff : even_sum_ff)} + {1'b0, square};
      tot_sum  = {1'b0, odd_sum_ff} + {1'b0, even_sum_ff};
      tot_sat  = tot_sum[SUM_W] ? '1 : tot_sum[SUM_W-1:0];

      div_start  = req_fire;
      mul_start  = (state_ff == S_DIV) && div_sts.done;
      root_start = 1'b0;

      state_in    = state_ff;
      order_in    = order_ff;
      last_in     = last_ff;
      ratio_in    = ratio_ff;
      odd_sum_in  = odd_sum_ff;
      even_sum_in = even_sum_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_ratio_in = rsp_ratio_ff;
      rsp_total_in = rsp_total_ff;
      rsp_odd_in   = rsp_odd_ff;
      rsp_even_in  = rsp_even_ff;
      rsp_thdv_in  = rsp_thdv_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               order_in = req_harmonic_order;
               last_in  = req_channel_end;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_sts.done) begin
               ratio_in = div_quot;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (mul_sts.done) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            if (in_range) begin
               if (order_ff[0]) begin
                  odd_sum_in = acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];
               end else begin
                  even_sum_in = acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];
               end
            end
            state_in = last_ff ? S_ROOT : S_FIN;
         end
         S_ROOT: begin
            // first cycle here: launch the roots on the updated sums, then clear
            if (!sq_sts[0].busy && !sq_sts[0].done) begin
               root_start  = 1'b1;
               odd_sum_in  = '0;
               even_sum_in = '0;
            end
            if (sq_sts[0].done) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ratio_in = ratio_ff;
               rsp_thdv_in  = last_ff;
               rsp_total_in = last_ff ? root_total : '0;
               rsp_odd_in   = last_ff ? root_odd : '0;
               rsp_even_in  = last_ff ? root_even : '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         odd_sum_ff   <= '0;
         even_sum_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         odd_sum_ff   <= odd_sum_in;
         even_sum_ff  <= even_sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      order_ff     <= order_in;
      last_ff      <= last_in;
      ratio_ff     <= ratio_in;
      rsp_ratio_ff <= rsp_ratio_in;
      rsp_total_ff <= rsp_total_in;
      rsp_odd_ff   <= rsp_odd_in;
      rsp_even_ff  <= rsp_even_in;
      rsp_thdv_ff  <= rsp_thdv_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_harmonic_ratio = rsp_ratio_ff;
   assign rsp_total_thd      = rsp_total_ff;
   assign rsp_odd_thd        = rsp_odd_ff;
   assign rsp_even_thd       = rsp_even_ff;
   assign rsp_thd_valid      = rsp_thdv_ff;

   // the three root units run in lockstep
   a_roots_lockstep: assert property (@(posedge clock) disable iff (reset)
      (sq_sts[0].done == sq_sts[1].done) && (sq_sts[0].done == sq_sts[2].done))
      else $error("square-root units out of step");

   // sums are cleared right after the roots are launched
   a_sums_cleared: assert property (@(posedge clock) disable iff (reset)
      root_start |=> (odd_sum_ff == '0) && (even_sum_ff == '0))
      else $error("sums not cleared after channel end");

   // divider finishes only while the sequencer waits for it
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> (state_ff == S_DIV))
      else $error("divider done outside its wait state");

   // a word without channel end carries zero THD fields
   a_thd_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_thdv_ff) |->
         (rsp_total_ff == '0) && (rsp_odd_ff == '0) && (rsp_even_ff == '0))
      else $error("THD fields set without channel end");

endmodule

`default_nettype wire
